[design/utf8_stream_sanitizer_unit_assert.svh]
// ----------------------------------------------------------------------------
// utf8 stream sanitizer assertion macros
// property helpers shared by the checker, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_SANITIZER_UNIT_ASSERT_SVH
`define UTF8_STREAM_SANITIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define U8S_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u8s check failed");

// next-cycle implication
`define U8S_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u8s check failed");

`endif

[design/u8s_pkg.sv]
// ----------------------------------------------------------------------------
// u8s_pkg
// shared types and constants of the utf8 stream sanitizer
// ----------------------------------------------------------------------------
`default_nettype none

package u8s_pkg;

	localparam logic [7:0] REPL0 = 8'hEF;
	localparam logic [7:0] REPL1 = 8'hBF;
	localparam logic [7:0] REPL2 = 8'hBD;

	// one request's worth of output, as planned by the front end
	typedef struct packed {
		logic [3:0][7:0] lit;
		logic [3:0]      pre_len;
		logic [3:0]      lit_end;
		logic [3:0]      total;
		logic            last;
		logic            valid;
	} entry_t;

endpackage

`default_nettype wire

[design/u8s_front.sv]
// ----------------------------------------------------------------------------
// u8s_front
// decoder state, held bytes and per-request output plan
// ----------------------------------------------------------------------------
`default_nettype none

module u8s_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     in_byte,
	input  wire logic           last_byte,
	input  wire logic           q_full,
	output logic                q_push,
	output u8s_pkg::entry_t     q_data
);

	localparam logic [7:0] CONT_MIN = 8'h80;
	localparam logic [7:0] CONT_MAX = 8'hBF;

	typedef struct packed {
		logic       ok;
		logic [1:0] pending;
		logic [7:0] cmin;
		logic [7:0] cmax;
	} scan_t;

	function automatic scan_t take_byte(input logic [1:0] pend, input logic [7:0] cmin,
		input logic [7:0] cmax, input logic [7:0] b);
		scan_t r;
		r.ok      = 1'b1;
		r.pending = pend;
		r.cmin    = cmin;
		r.cmax    = cmax;
		if (pend != 2'd0) begin
			if (b < cmin || b > cmax) begin
				r.ok = 1'b0;
			end else begin
				r.pending = pend - 2'd1;
				r.cmin    = CONT_MIN;
				r.cmax    = CONT_MAX;
			end
		end else if (b < 8'h80) begin
			r.ok = 1'b1;
		end else if (b < 8'hC2) begin
			r.ok = 1'b0;
		end else if (b < 8'hE0) begin
			r.pending = 2'd1;
			r.cmin    = CONT_MIN;
			r.cmax    = CONT_MAX;
		end else if (b < 8'hF0) begin
			r.pending = 2'd2;
			r.cmin    = (b == 8'hE0) ? 8'hA0 : CONT_MIN;
			r.cmax    = (b == 8'hED) ? 8'h9F : CONT_MAX;
		end else if (b < 8'hF5) begin
			r.pending = 2'd3;
			r.cmin    = (b == 8'hF0) ? 8'h90 : CONT_MIN;
			r.cmax    = (b == 8'hF4) ? 8'h8F : CONT_MAX;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	logic [1:0] pend_q;
	logic [7:0] cmin_q;
	logic [7:0] cmax_q;
	logic [1:0] hc_q;
	logic       err_q;
	logic [7:0] held_q [3];

	scan_t      scan1;
	scan_t      scan2;
	scan_t      st;
	logic [1:0] hc;
	logic       err_d;
	logic       acc;
	logic [2:0] pre;
	logic [2:0] lit_cnt;
	logic [1:0] post;
	logic [3:0] pre_len;
	logic [3:0] lit_end;
	logic [3:0] total;
	logic [7:0] held_d [3];
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		scan1   = take_byte(pend_q, cmin_q, cmax_q, in_byte);
		scan2   = take_byte(2'd0, CONT_MIN, CONT_MAX, in_byte);
		st      = scan1;
		hc      = hc_q;
		err_d   = err_q;
		acc     = 1'b1;
		pre     = 3'd0;
		lit_cnt = 3'd0;
		post    = 2'd0;
		held_d  = held_q;
		if (!scan1.ok) begin
			err_d = 1'b1;
			pre   = {1'b0, hc_q};
			hc    = 2'd0;
			st    = scan2;
			if (!scan2.ok) begin
				pre = pre + 3'd1;
				acc = 1'b0;
			end
		end
		// held bytes that survive come first, then the new byte
		for (int i = 0; i < 3; i++) begin
			q_data.lit[i] = (2'(i) < hc) ? held_q[i] : in_byte;
		end
		q_data.lit[3] = in_byte;
		if (acc) begin
			if (st.pending == 2'd0) begin
				lit_cnt = {1'b0, hc} + 3'd1;
				hc      = 2'd0;
			end else begin
				held_d[hc] = in_byte;
				hc         = hc + 2'd1;
			end
		end
		if (last_byte) begin
			if (hc != 2'd0) begin
				err_d = 1'b1;
			end
			post = hc;
		end
		pre_len = ({1'b0, pre} << 1) + {1'b0, pre};
		lit_end = pre_len + {1'b0, lit_cnt};
		total   = lit_end + ({2'b00, post} << 1) + {2'b00, post};
		q_data.pre_len = pre_len;
		q_data.lit_end = lit_end;
		q_data.total   = total;
		q_data.last    = last_byte;
		q_data.valid   = !err_d;
	end

	assign q_push = accept && (total != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			cmin_q <= CONT_MIN;
			cmax_q <= CONT_MAX;
			hc_q   <= 2'd0;
			err_q  <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				pend_q <= 2'd0;
				cmin_q <= CONT_MIN;
				cmax_q <= CONT_MAX;
				hc_q   <= 2'd0;
				err_q  <= 1'b0;
			end else begin
				pend_q <= acc ? st.pending : 2'd0;
				cmin_q <= acc ? st.cmin : CONT_MIN;
				cmax_q <= acc ? st.cmax : CONT_MAX;
				hc_q   <= hc;
				err_q  <= err_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_d;
		end
	end

endmodule

`default_nettype wire

[design/u8s_queue.sv]
// ----------------------------------------------------------------------------
// u8s_queue
// short fifo of output plans between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module u8s_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire u8s_pkg::entry_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output u8s_pkg::entry_t      head,
	output logic                 empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	u8s_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

[design/u8s_back.sv]
// ----------------------------------------------------------------------------
// u8s_back
// walks the plan at the queue head and sends one output byte per cycle while out_ready is high
// ----------------------------------------------------------------------------
`default_nettype none

module u8s_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire u8s_pkg::entry_t head,
	input  wire logic            q_empty,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_byte,
	output logic                 run_last,
	output logic                 is_replacement,
	output logic                 stream_end,
	output logic                 stream_valid
);

	logic [3:0] pos_q;
	logic [1:0] sub_q;
	logic [3:0] lit_off;
	logic       repl;
	logic       end_of;
	logic       fire;

	assign out_valid = !q_empty;
	assign fire      = out_valid && out_ready;
	assign lit_off   = pos_q - head.pre_len;
	assign repl      = (pos_q < head.pre_len) || (pos_q >= head.lit_end);
	assign end_of    = (pos_q == head.total - 4'd1);
	assign q_pop     = fire && end_of;

	always_comb begin
		if (repl) begin
			case (sub_q)
				2'd0:    out_byte = u8s_pkg::REPL0;
				2'd1:    out_byte = u8s_pkg::REPL1;
				default: out_byte = u8s_pkg::REPL2;
			endcase
		end else begin
			out_byte = head.lit[lit_off[1:0]];
		end
	end

	assign run_last       = end_of;
	assign is_replacement = repl;
	assign stream_end     = end_of && head.last;
	assign stream_valid   = end_of && head.last && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 4'd0;
			sub_q <= 2'd0;
		end else if (fire) begin
			pos_q <= end_of ? 4'd0 : pos_q + 4'd1;
			if (repl) begin
				sub_q <= (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[design/utf8_stream_sanitizer_unit.sv]
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer_unit
// Takes one raw byte per request and sends strict UTF-8: overlongs,
// surrogates and code points above U+10FFFF are rejected, each held byte of a
// broken sequence and each byte that stays ill-formed turns into EF BF BD,
// and the end of a stream flushes held bytes as replacements and reports
// whether the stream was clean. The front end takes a byte every cycle while
// its plan queue (QUEUE_DEPTH entries) has room; the back end sends one byte
// per cycle while out_ready is high, so an input request causes 0 to 12
// output bytes, and plain valid text runs at one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_sanitizer_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       last_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            run_last,
	output logic            is_replacement,
	output logic            stream_end,
	output logic            stream_valid
);

	u8s_pkg::entry_t push_data;
	u8s_pkg::entry_t head;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;

	u8s_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.last_byte (last_byte),
		.q_full    (full),
		.q_push    (push),
		.q_data    (push_data)
	);

	u8s_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	u8s_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_empty        (empty),
		.q_pop          (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.run_last       (run_last),
		.is_replacement (is_replacement),
		.stream_end     (stream_end),
		.stream_valid   (stream_valid)
	);

endmodule

`default_nettype wire

[design/u8s_checker.sv]
// ----------------------------------------------------------------------------
// u8s_checker
// port-level checks of the sanitizer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_stream_sanitizer_unit_assert.svh"

module u8s_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       run_last,
	input wire logic       is_replacement,
	input wire logic       stream_end,
	input wire logic       stream_valid
);

	// stalled output holds
	`U8S_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(run_last) && $stable(is_replacement)
		&& $stable(stream_end) && $stable(stream_valid))

	`U8S_ASSERT_SAME(a_valid_at_end, out_valid && stream_valid, stream_end)

	`U8S_ASSERT_SAME(a_end_is_last, out_valid && stream_end, run_last)

	`U8S_ASSERT_SAME(a_repl_bytes, out_valid && is_replacement,
		out_byte == u8s_pkg::REPL0 || out_byte == u8s_pkg::REPL1 || out_byte == u8s_pkg::REPL2)

	// a replacement sequence never breaks after its first byte
	`U8S_ASSERT_NEXT(a_repl_seq,
		out_valid && out_ready && is_replacement && out_byte == u8s_pkg::REPL0,
		out_valid && is_replacement && out_byte == u8s_pkg::REPL1)

endmodule

bind utf8_stream_sanitizer_unit u8s_checker u_u8s_checker (.*);

`default_nettype wire
